@@ rtl/weighted_score_cache_replacement_top_macros.svh @@
// Assertion macros for the weighted-score replacement block.
// Included by the modules that check their own control logic; no dependencies.
`ifndef WEIGHTED_SCORE_CACHE_REPLACEMENT_TOP_MACROS_SVH
`define WEIGHTED_SCORE_CACHE_REPLACEMENT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WSCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WSCR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WSCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define WSCR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/wscr_pkg.sv @@
// Shared types and constants of the weighted-score replacement block.
// No dependencies; used by the front end, the back end and the top level.
`timescale 1ns / 1ps

package wscr_pkg;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_HIT   = 2'd1,
    OP_FILL  = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  localparam int OP_W = 2;

  localparam logic CFG_PHASE_SPAN   = 1'b0;
  localparam logic CFG_DECAY_PERIOD = 1'b1;

  localparam logic [31:0] PHASE_SPAN_RST   = 32'd100000;
  localparam logic [15:0] DECAY_PERIOD_RST = 16'd1000;

  localparam logic [3:0]  W_AGE         = 4'd10;
  localparam logic [3:0]  W_USE         = 4'd15;
  localparam logic [5:0]  W_REUSE       = 6'd38;
  localparam logic [13:0] PHASE_PENALTY = 14'd10000;

  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int VICTIM_W = 4;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

@@ rtl/wscr_fifo.sv @@
// Small first-in first-out queue built from flip-flops.
// No dependencies.
`timescale 1ns / 1ps

module wscr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/wscr_front.sv @@
// Front end: accepts input transfers, classifies them and reduces the set index.
// Depends on wscr_pkg.
`timescale 1ns / 1ps

module wscr_front #(
  parameter int SETS = 2048,
  parameter int WAYS = 16,
  parameter int SET_W = 11,
  parameter int WAY_W = 4,
  parameter int CMD_W = 17
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_func,
  input  logic [wscr_pkg::SET_IN_W-1:0]       in_set_index,
  input  logic [wscr_pkg::WAY_IN_W-1:0]       in_way_index,
  input  logic                                in_hit,
  input  wscr_pkg::back_stat_t                stat,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [CMD_W-1:0]                    q_data
);

  localparam int SI_W  = wscr_pkg::SET_IN_W;
  localparam int MOD_K = 22;
  localparam int RC_W  = MOD_K + 1;
  localparam int PR_W  = SI_W + RC_W;
  localparam int RM_W  = 28;
  localparam logic [RC_W-1:0] MOD_RECIP = RC_W'((64'd1 << MOD_K) / SETS);

  logic                 fv_r;
  wscr_pkg::op_t        f_op_r;
  logic [SI_W-1:0]      f_set_r;
  logic [SI_W-1:0]      f_quo_r;
  logic [WAY_W-1:0]     f_way_r;
  logic                 accept;
  logic                 way_ok;
  logic [PR_W-1:0]      quo_prod;
  logic [RM_W-1:0]      rem0;
  logic [RM_W-1:0]      rem;
  wscr_pkg::op_t        op_nxt;

  assign in_full  = stat.clearing || (fv_r && q_full);
  assign accept   = in_push && !in_full;
  assign q_push   = fv_r && !q_full;
  assign way_ok   = ({2'b00, in_way_index} < 6'(WAYS));
  assign quo_prod = PR_W'(in_set_index) * PR_W'(MOD_RECIP);

  always_comb begin
    if (!in_func) begin
      op_nxt = wscr_pkg::OP_QUERY;
    end else if (!way_ok) begin
      op_nxt = wscr_pkg::OP_COUNT;
    end else if (in_hit) begin
      op_nxt = wscr_pkg::OP_HIT;
    end else begin
      op_nxt = wscr_pkg::OP_FILL;
    end
  end

  always_comb begin
    rem0 = RM_W'(f_set_r) - RM_W'(f_quo_r) * RM_W'(SETS);
    if (rem0 >= RM_W'(SETS)) begin
      rem = rem0 - RM_W'(SETS);
    end else begin
      rem = rem0;
    end
  end

  assign q_data = {f_op_r, rem[SET_W-1:0], f_way_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op_r  <= op_nxt;
      f_set_r <= in_set_index;
      f_quo_r <= SI_W'(quo_prod >> MOD_K);
      f_way_r <= WAY_W'(in_way_index);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (accept) begin
      fv_r <= 1'b1;
    end else if (q_push) begin
      fv_r <= 1'b0;
    end
  end

endmodule

@@ rtl/wscr_back.sv @@
// Back end: line metadata memory, victim scan, access update and decay sweep.
// Depends on wscr_pkg and the block's assertion macro header.
`timescale 1ns / 1ps
`include "weighted_score_cache_replacement_top_macros.svh"

module wscr_back #(
  parameter int SETS = 2048,
  parameter int WAYS = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int SET_W = 11,
  parameter int WAY_W = 4,
  parameter int CMD_W = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [31:0]                    phase_span,
  input  logic [15:0]                    decay_period,
  output wscr_pkg::back_stat_t           stat,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  input  logic [CMD_W-1:0]               cmd_data,
  input  logic                           res_full,
  output logic                           res_push,
  output logic [wscr_pkg::VICTIM_W-1:0]  res_way
);

  localparam int CW      = COUNT_WIDTH;
  localparam int LINE_W  = 96 + 2 * CW;
  localparam int ROW_W   = WAYS * LINE_W;
  localparam int USE_LO  = 64;
  localparam int REU_LO  = 64 + CW;
  localparam int PH_LO   = 64 + 2 * CW;
  localparam int SCORE_W = 72;
  localparam int VW      = wscr_pkg::VICTIM_W;
  localparam int V_W     = CW + 1;
  localparam int DEC_K   = CW + 4;
  localparam int P_W     = 2 * CW + 2;
  localparam int R_W     = CW + 5;
  localparam logic [V_W-1:0] DEC_RECIP = V_W'((64'd1 << DEC_K) / 10);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_READ  = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_CMP   = 8'b00010000,
    S_PUSH  = 8'b00100000,
    S_DECAY = 8'b01000000,
    S_DTAIL = 8'b10000000
  } state_t;

  function automatic logic [CW-1:0] decay9(input logic [CW-1:0] x);
    logic [V_W-1:0] v;
    logic [P_W-1:0] prod;
    logic [V_W-1:0] q;
    logic [R_W-1:0] r;
    v    = {1'b0, x} + V_W'(9);
    prod = P_W'(v) * P_W'(DEC_RECIP);
    q    = V_W'(prod >> DEC_K);
    r    = R_W'(v) - ((R_W'(q) << 3) + (R_W'(q) << 1));
    if (r >= R_W'(10)) begin
      q = q + 1'b1;
    end
    decay9 = CW'({1'b0, x} - q);
  endfunction

  logic [ROW_W-1:0] row_mem [SETS];
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_en;
  logic [SET_W-1:0] rd_addr;
  logic             wr_en;
  logic [SET_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;

  state_t               state_r;
  state_t               state_nxt;
  wscr_pkg::op_t        c_op_r;
  logic [SET_W-1:0]     c_set_r;
  logic [WAY_W-1:0]     c_way_r;
  logic [SET_W-1:0]     sweep_cnt_r;
  logic [SET_W-1:0]     dk_addr_r;
  logic                 dk_v_r;
  logic [WAY_W-1:0]     scan_cnt_r;
  logic                 sc_v_r;
  logic [WAY_W-1:0]     sc_way_r;
  logic [SCORE_W-1:0]   sc_score_r;
  logic [SCORE_W-1:0]   best_score_r;
  logic [WAY_W-1:0]     best_way_r;
  logic [63:0]          acc_cnt_r;
  logic [31:0]          cur_phase_r;
  logic [31:0]          phase_cnt_r;
  logic [15:0]          decay_cnt_r;

  wscr_pkg::op_t        cmd_op;
  logic [SET_W-1:0]     cmd_set;
  logic [WAY_W-1:0]     cmd_way;
  logic [63:0]          acc_nxt;
  logic                 dec_fire;
  logic                 ph_fire;
  logic [ROW_W-1:0]     upd_row;
  logic [ROW_W-1:0]     dec_row;
  logic [LINE_W-1:0]    scan_line;
  logic [63:0]          age;
  logic [SCORE_W-1:0]   score;
  logic                 scan_last;

  assign cmd_op  = wscr_pkg::op_t'(cmd_data[CMD_W-1 -: wscr_pkg::OP_W]);
  assign cmd_set = cmd_data[WAY_W +: SET_W];
  assign cmd_way = cmd_data[WAY_W-1:0];

  assign acc_nxt  = acc_cnt_r + 64'd1;
  assign dec_fire = ({1'b0, decay_cnt_r} + 17'd1) >= {1'b0, decay_period};
  assign ph_fire  = ({1'b0, phase_cnt_r} + 33'd1) >= {1'b0, phase_span};

  always_comb begin
    upd_row = rd_data_r;
    dec_row = rd_data_r;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == c_way_r) begin
        upd_row[w*LINE_W +: 64] = acc_nxt;
        if (c_op_r == wscr_pkg::OP_HIT) begin
          if (rd_data_r[w*LINE_W+USE_LO +: CW] != {CW{1'b1}}) begin
            upd_row[w*LINE_W+USE_LO +: CW] = rd_data_r[w*LINE_W+USE_LO +: CW] + 1'b1;
          end
          if (rd_data_r[w*LINE_W+REU_LO +: CW] != {CW{1'b1}}) begin
            upd_row[w*LINE_W+REU_LO +: CW] = rd_data_r[w*LINE_W+REU_LO +: CW] + 1'b1;
          end
        end else begin
          upd_row[w*LINE_W+USE_LO +: CW] = CW'(1);
          upd_row[w*LINE_W+REU_LO +: CW] = '0;
          upd_row[w*LINE_W+PH_LO +: 32]  = cur_phase_r;
        end
      end
      dec_row[w*LINE_W+USE_LO +: CW] = decay9(rd_data_r[w*LINE_W+USE_LO +: CW]);
      dec_row[w*LINE_W+REU_LO +: CW] = decay9(rd_data_r[w*LINE_W+REU_LO +: CW]);
    end
  end

  assign scan_line = rd_data_r[scan_cnt_r*LINE_W +: LINE_W];
  assign age       = acc_cnt_r - scan_line[63:0];
  assign score     = SCORE_W'(age) * SCORE_W'(wscr_pkg::W_AGE)
                   + SCORE_W'(scan_line[USE_LO +: CW]) * SCORE_W'(wscr_pkg::W_USE)
                   + SCORE_W'(scan_line[REU_LO +: CW]) * SCORE_W'(wscr_pkg::W_REUSE)
                   + ((scan_line[PH_LO +: 32] != cur_phase_r)
                      ? SCORE_W'(wscr_pkg::PHASE_PENALTY) : '0);
  assign scan_last = (scan_cnt_r == WAY_W'(WAYS - 1));

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = cmd_set;
    wr_en     = 1'b0;
    wr_addr   = c_set_r;
    wr_data   = upd_row;
    cmd_pop   = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_cnt_r;
        wr_data = '0;
        if (sweep_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          rd_en     = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (c_op_r == wscr_pkg::OP_QUERY) begin
          state_nxt = S_SCAN;
        end else begin
          wr_en     = (c_op_r == wscr_pkg::OP_HIT) || (c_op_r == wscr_pkg::OP_FILL);
          state_nxt = dec_fire ? S_DECAY : S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      S_DECAY: begin
        rd_en   = 1'b1;
        rd_addr = sweep_cnt_r;
        wr_en   = dk_v_r;
        wr_addr = dk_addr_r;
        wr_data = dec_row;
        if (sweep_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = S_DTAIL;
        end
      end
      S_DTAIL: begin
        wr_en     = dk_v_r;
        wr_addr   = dk_addr_r;
        wr_data   = dec_row;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= row_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      c_op_r  <= cmd_op;
      c_set_r <= cmd_set;
      c_way_r <= cmd_way;
    end
    if (state_r == S_DECAY) begin
      dk_addr_r <= sweep_cnt_r;
    end
    sc_way_r   <= scan_cnt_r;
    sc_score_r <= score;
    if (sc_v_r && ((sc_way_r == '0) || (sc_score_r < best_score_r))) begin
      best_score_r <= sc_score_r;
      best_way_r   <= sc_way_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_cnt_r <= '0;
      dk_v_r      <= 1'b0;
      scan_cnt_r  <= '0;
      sc_v_r      <= 1'b0;
      acc_cnt_r   <= '0;
      cur_phase_r <= '0;
      phase_cnt_r <= '0;
      decay_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      sc_v_r  <= (state_r == S_SCAN);
      dk_v_r  <= (state_r == S_DECAY);
      if ((state_r == S_CLEAR) || (state_r == S_DECAY)) begin
        sweep_cnt_r <= (sweep_cnt_r == SET_W'(SETS - 1)) ? '0 : sweep_cnt_r + 1'b1;
      end
      if (state_r == S_SCAN) begin
        scan_cnt_r <= scan_last ? '0 : scan_cnt_r + 1'b1;
      end
      if ((state_r == S_READ) && (c_op_r != wscr_pkg::OP_QUERY)) begin
        acc_cnt_r   <= acc_nxt;
        decay_cnt_r <= dec_fire ? '0 : decay_cnt_r + 16'd1;
        phase_cnt_r <= ph_fire ? '0 : phase_cnt_r + 32'd1;
        if (ph_fire) begin
          cur_phase_r <= cur_phase_r + 32'd1;
        end
      end
    end
  end

  assign stat.clearing = (state_r == S_CLEAR);
  assign res_push      = (state_r == S_PUSH) && !res_full;
  assign res_way       = VW'(best_way_r);

  `WSCR_ASSERT_NEVER(a_push_into_full, clk, rst_n, res_push && res_full, "result written into full queue")
  `WSCR_ASSERT_NEVER(a_pop_in_sweep, clk, rst_n, cmd_pop && (dk_v_r || stat.clearing), "command taken during a sweep")
  `WSCR_ASSERT(a_tail_to_idle, clk, rst_n, (state_r == S_DTAIL) |=> (state_r == S_IDLE), "decay sweep did not finish")
  `WSCR_ASSERT(a_best_in_range, clk, rst_n, (state_r == S_PUSH) |-> (best_way_r <= WAY_W'(WAYS - 1)), "victim beyond ways")

endmodule

@@ rtl/weighted_score_cache_replacement_top.sv @@
// Top level of the weighted-score replacement block: configuration registers and queues.
// Depends on wscr_pkg, wscr_fifo, wscr_front and wscr_back.
`timescale 1ns / 1ps
//
//  channel  handshake           payload
//  in       in_push / in_full   in_func, in_set_index, in_way_index, in_hit
//  out      out_pop / out_empty out_victim_way
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A victim query scans the set in the back end one way per cycle.
// A hit or fill reads and rewrites the set's row; every decay period adds a sweep of all SETS rows.
// After reset the metadata memory is cleared row by row, during which in_full is high.
// Two-entry queues decouple the front end, the back end and the result port.

module weighted_score_cache_replacement_top #(
  parameter int SETS = 2048,
  parameter int WAYS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_func,
  input  logic [wscr_pkg::SET_IN_W-1:0]  in_set_index,
  input  logic [wscr_pkg::WAY_IN_W-1:0]  in_way_index,
  input  logic                           in_hit,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [wscr_pkg::VICTIM_W-1:0]  out_victim_way,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = $clog2(WAYS);
  localparam int CMD_W = wscr_pkg::OP_W + SET_W + WAY_W;

  logic [31:0]          phase_span_r;
  logic [15:0]          decay_period_r;
  wscr_pkg::back_stat_t stat;
  logic                 q_push;
  logic                 q_full;
  logic [CMD_W-1:0]     q_wdata;
  logic [CMD_W-1:0]     q_rdata;
  logic                 q_empty;
  logic                 q_pop;
  logic                 res_push;
  logic                 res_full;
  logic [wscr_pkg::VICTIM_W-1:0] res_way;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_span_r   <= wscr_pkg::PHASE_SPAN_RST;
      decay_period_r <= wscr_pkg::DECAY_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wscr_pkg::CFG_PHASE_SPAN:   phase_span_r   <= cfg_data;
        wscr_pkg::CFG_DECAY_PERIOD: decay_period_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  wscr_front #(
    .SETS(SETS), .WAYS(WAYS), .SET_W(SET_W), .WAY_W(WAY_W), .CMD_W(CMD_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_func(in_func),
    .in_set_index(in_set_index), .in_way_index(in_way_index), .in_hit(in_hit),
    .stat(stat), .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  wscr_fifo #(.W(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  wscr_back #(
    .SETS(SETS), .WAYS(WAYS), .COUNT_WIDTH(COUNT_WIDTH),
    .SET_W(SET_W), .WAY_W(WAY_W), .CMD_W(CMD_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .phase_span(phase_span_r), .decay_period(decay_period_r),
    .stat(stat), .cmd_empty(q_empty), .cmd_pop(q_pop), .cmd_data(q_rdata),
    .res_full(res_full), .res_push(res_push), .res_way(res_way)
  );

  wscr_fifo #(.W(wscr_pkg::VICTIM_W), .DEPTH(2)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .push_data(res_way), .full(res_full),
    .pop(out_pop), .pop_data(out_victim_way), .empty(out_empty)
  );

endmodule
